/* design/scw_pkg.sv */
package scw_pkg;

	localparam int CW = 6;
	localparam int LW = 7;

	typedef enum logic [1:0] {
		F_LOAD  = 2'd0,
		F_MARK  = 2'd1,
		F_START = 2'd2,
		F_STEP  = 2'd3
	} func_t;

	localparam logic [1:0] DIR_PX = 2'd0;
	localparam logic [1:0] DIR_PY = 2'd1;
	localparam logic [1:0] DIR_MX = 2'd2;
	localparam logic [1:0] DIR_MY = 2'd3;

	localparam logic [1:0] LAST_PROBE = 2'd3;

	localparam logic [1:0] CFG_COLS = 2'd0;
	localparam logic [1:0] CFG_ROWS = 2'd1;

	typedef struct packed {
		logic          ok;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
	} nbr_t;

endpackage

/* design/scw_ram.sv */
module scw_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/scw_nbr.sv */
module scw_nbr #(
	parameter int EFF_COLS = 64,
	parameter int AW = 12
) (
	input  logic [scw_pkg::CW-1:0] x,
	input  logic [scw_pkg::CW-1:0] y,
	input  logic [1:0]             dir,
	input  logic                   move,
	input  logic [scw_pkg::LW-1:0] cols_lim,
	input  logic [scw_pkg::LW-1:0] rows_lim,
	output scw_pkg::nbr_t          nbr,
	output logic [AW-1:0]          addr
);
	import scw_pkg::*;

	localparam int AFW = 2 * CW + 1;

	logic [CW:0]    nx;
	logic [CW:0]    ny;
	logic           neg;
	logic [AFW-1:0] full;

	always_comb begin
		nx  = {1'b0, x};
		ny  = {1'b0, y};
		neg = 1'b0;
		if (move) begin
			case (dir)
				DIR_PX: begin
					nx = nx + 1'b1;
				end
				DIR_PY: begin
					ny = ny + 1'b1;
				end
				DIR_MX: begin
					neg = (x == '0);
					nx  = nx - 1'b1;
				end
				default: begin
					neg = (y == '0);
					ny  = ny - 1'b1;
				end
			endcase
		end
	end

	assign nbr.ok = !neg && (nx < cols_lim) && (ny < rows_lim);
	assign nbr.x  = nx[CW-1:0];
	assign nbr.y  = ny[CW-1:0];

	assign full = AFW'(ny[CW-1:0]) * AFW'(EFF_COLS) + AFW'(nx[CW-1:0]);
	assign addr = full[AW-1:0];

endmodule

/* design/spiral_coverage_walker_top.sv */
// Spiral coverage walker. Load, mark and start items never raise busy, and the result
// strobe comes in the cycle after start. A step item that comes while the walk is over
// behaves the same way. Any other step item probes up to four neighbours in turn: for
// each one inside the grid a probe state reads the occupancy and visited RAMs and a check
// state then tests them; a neighbour outside it takes only the probe state. Each map RAM
// has a single read port. Each result is shown on done for exactly one cycle and must be
// taken then.
module spiral_coverage_walker_top #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             func,
	input  logic [scw_pkg::CW-1:0] cell_x,
	input  logic [scw_pkg::CW-1:0] cell_y,
	input  logic                   blocked,
	input  logic [scw_pkg::CW-1:0] prev_x,
	input  logic [scw_pkg::CW-1:0] prev_y,
	input  logic                   use_heading,
	output logic                   done,
	output logic [scw_pkg::CW-1:0] out_x,
	output logic [scw_pkg::CW-1:0] out_y,
	output logic                   advanced,
	output logic                   finished,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [scw_pkg::LW-1:0] cfg_data
);
	import scw_pkg::*;

	localparam int EFF_COLS = (MAX_COLS > 64) ? 64 : MAX_COLS;
	localparam int EFF_ROWS = (MAX_ROWS > 64) ? 64 : MAX_ROWS;
	localparam int DEPTH    = EFF_COLS * EFF_ROWS;
	localparam int AW       = $clog2(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_PROBE = 3'b010,
		S_CHECK = 3'b100
	} state_t;

	state_t        state_q;
	logic [LW-1:0] cols_q;
	logic [LW-1:0] rows_q;
	logic [LW-1:0] cols_lim;
	logic [LW-1:0] rows_lim;
	logic [CW-1:0] cur_x_q;
	logic [CW-1:0] cur_y_q;
	logic [1:0]    head_q;
	logic          head_v_q;
	logic          over_q;
	logic [1:0]    dir0_q;
	logic [1:0]    probe_q;
	logic [1:0]    probe_dir;
	logic [CW-1:0] nb_x_q;
	logic [CW-1:0] nb_y_q;
	logic [AW-1:0] nb_addr_q;
	logic [CW-1:0] res_x_q;
	logic [CW-1:0] res_y_q;
	logic          res_adv_q;
	logic          res_fin_q;
	logic          done_q;

	logic          accept;
	nbr_t          cmd_nbr;
	nbr_t          step_nbr;
	logic [AW-1:0] cmd_addr;
	logic [AW-1:0] step_addr;
	logic          occ_we;
	logic          vis_we;
	logic          vis_wd;
	logic [AW-1:0] vis_waddr;
	logic          occ_rd;
	logic          vis_rd;
	logic          qual;
	logic [1:0]    st_head;
	logic          st_hv;

	assign cols_lim  = (cols_q > LW'(EFF_COLS)) ? LW'(EFF_COLS) : cols_q;
	assign rows_lim  = (rows_q > LW'(EFF_ROWS)) ? LW'(EFF_ROWS) : rows_q;
	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign probe_dir = dir0_q - probe_q;

	scw_nbr #(.EFF_COLS(EFF_COLS), .AW(AW)) u_cmd_nbr (
		.x(cell_x), .y(cell_y), .dir(DIR_PX), .move(1'b0),
		.cols_lim(cols_lim), .rows_lim(rows_lim), .nbr(cmd_nbr), .addr(cmd_addr)
	);

	scw_nbr #(.EFF_COLS(EFF_COLS), .AW(AW)) u_step_nbr (
		.x(cur_x_q), .y(cur_y_q), .dir(probe_dir), .move(1'b1),
		.cols_lim(cols_lim), .rows_lim(rows_lim), .nbr(step_nbr), .addr(step_addr)
	);

	assign qual   = !occ_rd && !vis_rd;
	assign occ_we = accept && (func == F_LOAD) && cmd_nbr.ok;

	always_comb begin
		vis_we    = 1'b0;
		vis_wd    = 1'b1;
		vis_waddr = cmd_addr;
		if (state_q == S_CHECK) begin
			vis_we    = qual;
			vis_waddr = nb_addr_q;
		end else if (accept && cmd_nbr.ok) begin
			if (func == F_LOAD) begin
				vis_we = 1'b1;
				vis_wd = blocked;
			end else if (func == F_MARK) begin
				vis_we = 1'b1;
			end
		end
	end

	scw_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_occ_ram (
		.clk(clk), .we(occ_we), .waddr(cmd_addr), .wdata(blocked),
		.raddr(step_addr), .rdata(occ_rd)
	);

	scw_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_vis_ram (
		.clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wd),
		.raddr(step_addr), .rdata(vis_rd)
	);

	always_comb begin
		st_hv   = 1'b0;
		st_head = DIR_PX;
		if (use_heading) begin
			if (({1'b0, cell_x} == {1'b0, prev_x} + 1'b1) && (cell_y == prev_y)) begin
				st_hv   = 1'b1;
				st_head = DIR_PX;
			end else if (({1'b0, cell_y} == {1'b0, prev_y} + 1'b1) && (cell_x == prev_x)) begin
				st_hv   = 1'b1;
				st_head = DIR_PY;
			end else if (({1'b0, prev_x} == {1'b0, cell_x} + 1'b1) && (cell_y == prev_y)) begin
				st_hv   = 1'b1;
				st_head = DIR_MX;
			end else if (({1'b0, prev_y} == {1'b0, cell_y} + 1'b1) && (cell_x == prev_x)) begin
				st_hv   = 1'b1;
				st_head = DIR_MY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= LW'(64);
			rows_q <= LW'(64);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_COLS) begin
				cols_q <= cfg_data;
			end else if (cfg_index == CFG_ROWS) begin
				rows_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			head_q    <= DIR_PX;
			head_v_q  <= 1'b0;
			over_q    <= 1'b1;
			dir0_q    <= '0;
			probe_q   <= '0;
			nb_x_q    <= '0;
			nb_y_q    <= '0;
			nb_addr_q <= '0;
			res_x_q   <= '0;
			res_y_q   <= '0;
			res_adv_q <= 1'b0;
			res_fin_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_x_q   <= cur_x_q;
						res_y_q   <= cur_y_q;
						res_adv_q <= 1'b0;
						res_fin_q <= 1'b0;
						case (func)
							F_START: begin
								cur_x_q  <= cell_x;
								cur_y_q  <= cell_y;
								head_q   <= st_head;
								head_v_q <= st_hv;
								over_q   <= 1'b0;
								res_x_q  <= cell_x;
								res_y_q  <= cell_y;
								done_q   <= 1'b1;
							end
							F_STEP: begin
								if (over_q) begin
									res_fin_q <= 1'b1;
									done_q    <= 1'b1;
								end else begin
									dir0_q  <= (head_v_q ? head_q : DIR_PX) + 1'b1;
									probe_q <= '0;
									state_q <= S_PROBE;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_PROBE: begin
					if (step_nbr.ok) begin
						nb_x_q    <= step_nbr.x;
						nb_y_q    <= step_nbr.y;
						nb_addr_q <= step_addr;
						state_q   <= S_CHECK;
					end else if (probe_q == LAST_PROBE) begin
						over_q    <= 1'b1;
						res_fin_q <= 1'b1;
						done_q    <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						probe_q <= probe_q + 1'b1;
					end
				end
				S_CHECK: begin
					if (qual) begin
						cur_x_q   <= nb_x_q;
						cur_y_q   <= nb_y_q;
						head_q    <= probe_dir;
						head_v_q  <= 1'b1;
						res_x_q   <= nb_x_q;
						res_y_q   <= nb_y_q;
						res_adv_q <= 1'b1;
						done_q    <= 1'b1;
						state_q   <= S_IDLE;
					end else if (probe_q == LAST_PROBE) begin
						over_q    <= 1'b1;
						res_fin_q <= 1'b1;
						done_q    <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						probe_q <= probe_q + 1'b1;
						state_q <= S_PROBE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign out_x    = res_x_q;
	assign out_y    = res_y_q;
	assign advanced = res_adv_q;
	assign finished = res_fin_q;

	a_no_adv_and_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(advanced && finished))
		else $error("step reported both a move and the end of the walk");

	a_cmd_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (func != F_STEP)) |=> (done && !advanced && !finished))
		else $error("load, mark or start item did not give a plain result");

	a_check_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> ($past(state_q) == S_PROBE))
		else $error("check cycle without a preceding map read");

	a_step_write_open: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_CHECK) && vis_we) |-> (!occ_rd && !vis_rd && busy))
		else $error("step marked a cell that was blocked or visited");

	a_no_done_while_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && done) |-> 1'b0)
		else $error("result strobe while a step is still probing");

endmodule

/* dv/tb_spiral_coverage_walker_top.sv */
`timescale 1ns / 1ps

module tb_spiral_coverage_walker_top;
	import scw_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int ITEM_TARGET = 1750;
	localparam int GRID_MAX = 64;

	typedef struct {
		func_t         op;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic          blk;
		logic [CW-1:0] px;
		logic [CW-1:0] py;
		logic          uh;
	} walk_cmd_t;

	typedef struct {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic          adv;
		logic          fin;
	} walk_pos_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	logic [1:0]    func = F_LOAD;
	logic [CW-1:0] cell_x = '0;
	logic [CW-1:0] cell_y = '0;
	logic          blocked = 1'b0;
	logic [CW-1:0] prev_x = '0;
	logic [CW-1:0] prev_y = '0;
	logic          use_heading = 1'b0;
	logic          done;
	logic [CW-1:0] out_x;
	logic [CW-1:0] out_y;
	logic          advanced;
	logic          finished;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [1:0]    cfg_index = CFG_COLS;
	logic [LW-1:0] cfg_data = '0;

	walk_cmd_t cmd_queue[$];
	walk_cmd_t cmd_cur;
	walk_pos_t pos_due[$];

	bit            occ_map[GRID_MAX*GRID_MAX];
	bit            seen_map[GRID_MAX*GRID_MAX];
	bit            wall_plan[GRID_MAX*GRID_MAX];
	logic [CW-1:0] at_x = '0;
	logic [CW-1:0] at_y = '0;
	logic [1:0]    heading = DIR_PX;
	bit            heading_ok = 1'b0;
	bit            walk_done = 1'b1;
	int            grid_cols = GRID_MAX;
	int            grid_rows = GRID_MAX;

	int gap_pct = 7;
	int cmd_count = 0;
	int err_count = 0;
	int quiet = 0;

	spiral_coverage_walker_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.blocked    (blocked),
		.prev_x     (prev_x),
		.prev_y     (prev_y),
		.use_heading(use_heading),
		.done       (done),
		.out_x      (out_x),
		.out_y      (out_y),
		.advanced   (advanced),
		.finished   (finished),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int dir_dx(logic [1:0] d);
		case (d)
			DIR_PX: return 1;
			DIR_MX: return -1;
			default: return 0;
		endcase
	endfunction

	function automatic int dir_dy(logic [1:0] d);
		case (d)
			DIR_PY: return 1;
			DIR_MY: return -1;
			default: return 0;
		endcase
	endfunction

	function automatic bit on_grid(int x, int y);
		return x >= 0 && y >= 0 && x < grid_cols && y < grid_rows;
	endfunction

	function automatic int cell_at(int x, int y);
		return y * GRID_MAX + x;
	endfunction

	function automatic walk_pos_t walk_predict(walk_cmd_t c);
		walk_pos_t  r;
		logic [1:0] d;
		int         nx;
		int         ny;
		bit         moved;
		r.adv = 1'b0;
		r.fin = 1'b0;
		moved = 1'b0;
		case (c.op)
			F_LOAD: begin
				if (on_grid(int'(c.x), int'(c.y))) begin
					occ_map[cell_at(int'(c.x), int'(c.y))] = c.blk;
					seen_map[cell_at(int'(c.x), int'(c.y))] = c.blk;
				end
			end
			F_MARK: begin
				if (on_grid(int'(c.x), int'(c.y)))
					seen_map[cell_at(int'(c.x), int'(c.y))] = 1'b1;
			end
			F_START: begin
				at_x = c.x;
				at_y = c.y;
				heading = DIR_PX;
				heading_ok = 1'b0;
				if (c.uh) begin
					for (int i = 0; i < 4; i++) begin
						if (int'(c.x) - int'(c.px) == dir_dx(i[1:0]) &&
							int'(c.y) - int'(c.py) == dir_dy(i[1:0])) begin
							heading = i[1:0];
							heading_ok = 1'b1;
						end
					end
				end
				walk_done = 1'b0;
			end
			F_STEP: begin
				if (walk_done) begin
					r.fin = 1'b1;
				end else begin
					d = (heading_ok ? heading : DIR_PX) + 2'd1;
					for (int i = 0; i < 4 && !moved; i++) begin
						nx = int'(at_x) + dir_dx(d);
						ny = int'(at_y) + dir_dy(d);
						if (on_grid(nx, ny) && !occ_map[cell_at(nx, ny)] &&
							!seen_map[cell_at(nx, ny)]) begin
							seen_map[cell_at(nx, ny)] = 1'b1;
							at_x = nx[CW-1:0];
							at_y = ny[CW-1:0];
							heading = d;
							heading_ok = 1'b1;
							moved = 1'b1;
						end else begin
							d = d - 2'd1;
						end
					end
					if (moved) begin
						r.adv = 1'b1;
					end else begin
						r.fin = 1'b1;
						walk_done = 1'b1;
					end
				end
			end
		endcase
		r.x = at_x;
		r.y = at_y;
		return r;
	endfunction

	always @(posedge clk) begin
		if (start && !busy)
			pos_due = {pos_due, walk_predict(cmd_cur)};
		if (!start || !busy) begin
			if (cmd_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
				cmd_cur = cmd_queue.pop_front();
				func <= cmd_cur.op;
				cell_x <= cmd_cur.x;
				cell_y <= cmd_cur.y;
				blocked <= cmd_cur.blk;
				prev_x <= cmd_cur.px;
				prev_y <= cmd_cur.py;
				use_heading <= cmd_cur.uh;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		walk_pos_t want;
		if (done) begin
			if (pos_due.size() == 0) begin
				$display("%0t: result with no item pending, expected none, got x=%0d y=%0d",
					$time, out_x, out_y);
				err_count++;
			end else begin
				want = pos_due.pop_front();
				check_field("out_x", int'(want.x), int'(out_x));
				check_field("out_y", int'(want.y), int'(out_y));
				check_field("advanced", int'(want.adv), int'(advanced));
				check_field("finished", int'(want.fin), int'(finished));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet = quiet + 1;
		if (quiet == QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send(func_t op, int x, int y, int blk, int px, int py, int uh);
		walk_cmd_t c;
		c.op = op;
		c.x = x[CW-1:0];
		c.y = y[CW-1:0];
		c.blk = blk[0];
		c.px = px[CW-1:0];
		c.py = py[CW-1:0];
		c.uh = uh[0];
		cmd_queue = {cmd_queue, c};
		if ((op != F_LOAD && op != F_MARK) || on_grid(x, y))
			cmd_count++;
	endtask

	task automatic send_rand(func_t op);
		send(op, $urandom_range(63), $urandom_range(63), $urandom_range(1),
			$urandom_range(63), $urandom_range(63), $urandom_range(1));
	endtask

	task automatic wait_drained();
		while (cmd_queue.size() != 0 || start)
			@(negedge clk);
	endtask

	task automatic wait_idle();
		wait_drained();
		while (pos_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, int val);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= val[LW-1:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_COLS)
			grid_cols = (val > GRID_MAX) ? GRID_MAX : val;
		else
			grid_rows = (val > GRID_MAX) ? GRID_MAX : val;
		@(negedge clk);
	endtask

	task automatic set_grid(int ncols, int nrows);
		wait_idle();
		cfg_write(CFG_COLS, ncols);
		cfg_write(CFG_ROWS, nrows);
	endtask

	// Every cell of the grid is loaded before a walk, so no step reads an unwritten cell.
	task automatic run_walk();
		int         ncols;
		int         nrows;
		int         sx;
		int         sy;
		int         px;
		int         py;
		int         uh;
		int         pick;
		int         lim;
		bit         blk;
		logic [1:0] dir;
		ncols = grid_cols;
		nrows = grid_rows;
		for (int y = 0; y < nrows; y++) begin
			for (int x = 0; x < ncols; x++) begin
				blk = ($urandom_range(99) < 22);
				wall_plan[cell_at(x, y)] = blk;
				send(F_LOAD, x, y, int'(blk), $urandom_range(63), $urandom_range(63),
					$urandom_range(1));
			end
		end
		if ($urandom_range(2) == 0) begin
			repeat ($urandom_range(1, 3))
				send(F_MARK, $urandom_range(ncols - 1), $urandom_range(nrows - 1),
					$urandom_range(1), $urandom_range(63), $urandom_range(63),
					$urandom_range(1));
			send_rand(F_MARK);
		end
		if ($urandom_range(9) == 0) begin
			sx = $urandom_range(63);
			sy = $urandom_range(63);
		end else begin
			for (int t = 0; t < 20; t++) begin
				sx = $urandom_range(ncols - 1);
				sy = $urandom_range(nrows - 1);
				if (!wall_plan[cell_at(sx, sy)])
					break;
			end
		end
		pick = $urandom_range(99);
		px = $urandom_range(63);
		py = $urandom_range(63);
		uh = (pick < 85) ? 1 : 0;
		if (pick < 70) begin
			dir = 2'($urandom_range(3));
			px = sx - dir_dx(dir);
			py = sy - dir_dy(dir);
		end
		if ($urandom_range(1))
			send(F_MARK, sx, sy, $urandom_range(1), px, py, $urandom_range(1));
		send(F_START, sx, sy, $urandom_range(1), px, py, uh);
		wait_drained();
		lim = ncols * nrows / 6 + 2;
		for (int b = 0; b < lim && !walk_done; b++) begin
			repeat (6) begin
				if ($urandom_range(99) < 4)
					send_rand(func_t'($urandom_range(3)));
				send_rand(F_STEP);
			end
			wait_drained();
		end
		if ($urandom_range(1))
			send_rand(F_STEP);
	endtask

	initial begin
		int p;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_rand(F_STEP);
		send(F_LOAD, 63, 63, 1, 0, 0, 0);
		send(F_LOAD, 0, 0, 0, 63, 63, 1);
		send(F_MARK, 63, 63, 0, 0, 0, 0);
		set_grid(3, 2);
		for (int y = 0; y < 2; y++)
			for (int x = 0; x < 3; x++)
				send(F_LOAD, x, y, (x == 1 && y == 0) ? 1 : 0, 0, 0, 0);
		send(F_LOAD, 63, 1, 0, 0, 0, 0);
		send(F_MARK, 0, 63, 1, 0, 0, 0);
		send(F_MARK, 2, 1, 0, 0, 0, 0);
		send(F_START, 0, 0, 0, 63, 63, 1);
		repeat (4) send_rand(F_STEP);
		send(F_START, 0, 0, 0, 1, 0, 1);
		send_rand(F_STEP);
		send(F_START, 2, 1, 0, 2, 0, 1);
		send_rand(F_STEP);
		send(F_START, 63, 63, 0, 62, 63, 1);
		send_rand(F_STEP);

		p = 0;
		while (cmd_count < ITEM_TARGET) begin
			gap_pct = (p >= 5 && p <= 7) ? 0 : 7;
			if (p % 4 == 0) begin
				case ((p / 4) % 4)
					0: set_grid(64, 1);
					1: set_grid(1, 64);
					2: set_grid(1, 1);
					default: set_grid($urandom_range(30, 64), $urandom_range(1, 3));
				endcase
			end else begin
				set_grid($urandom_range(2, 12), $urandom_range(2, 12));
			end
			repeat ($urandom_range(1, 2))
				run_walk();
			p++;
		end

		wait_idle();
		repeat (20) @(negedge clk);
		if (err_count == 0 && pos_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* filelist.f */
design/scw_pkg.sv
design/scw_ram.sv
design/scw_nbr.sv
design/spiral_coverage_walker_top.sv
dv/tb_spiral_coverage_walker_top.sv
